// File: design/four_ary_min_heap_sift_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the four-ary min-heap sift block
// Immediate-consequence and next-cycle property wrappers with reset disable.
// ----------------------------------------------------------------------------
`ifndef FOUR_ARY_MIN_HEAP_SIFT_ASSERT_SVH
`define FOUR_ARY_MIN_HEAP_SIFT_ASSERT_SVH

`ifndef ASSERT_OFF

`define FMH_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define FMH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define FMH_ASSERT_NOW(label, clk, rst, ante, cons)

`define FMH_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: design/fmh_pkg.sv
// ----------------------------------------------------------------------------
// fmh_pkg
// Types, constants and slot arithmetic shared by the heap sift modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fmh_pkg;

   localparam int SLOT_W     = 8;
   localparam int CNT_W      = 9;
   localparam int KEY_W      = 64;
   localparam int HDL_W      = 16;
   localparam int LANES      = 4;
   localparam int LANE_W     = 2;
   localparam int ROW_FULL_W = SLOT_W - 1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef enum logic [1:0] {
      FUNC_UP     = 2'd0,
      FUNC_DOWN   = 2'd1,
      FUNC_ADJUST = 2'd2,
      FUNC_WRITE  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_UP_CMP,
      ST_DN_PAIR,
      ST_DN_MIN,
      ST_DN_MOVE,
      ST_PLACE,
      ST_ERROR
   } state_type;

   typedef struct packed {
      logic [HDL_W-1:0] moved_handle;
      logic [CNT_W-1:0] position;
      logic             status;
      logic             last;
   } result_type;

   typedef struct packed {
      logic              en;
      logic [LANE_W-1:0] lane;
      logic [KEY_W-1:0]  key;
      logic [HDL_W-1:0]  handle;
   } wr_type;

   // slot s sits at address s+3, so the children of any slot fill one row
   function automatic logic [ROW_FULL_W-1:0] row_of(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W:0] addr;
      addr = {1'b0, slot} + (SLOT_W+1)'(LANES - 1);
      return addr[SLOT_W:LANE_W];
   endfunction

   function automatic logic [LANE_W-1:0] lane_of(input logic [SLOT_W-1:0] slot);
      return slot[LANE_W-1:0] + LANE_W'(LANES - 1);
   endfunction

   function automatic logic [SLOT_W-1:0] parent_of(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] dec;
      dec = slot - SLOT_W'(1);
      return dec >> LANE_W;
   endfunction

endpackage

`default_nettype wire

// File: design/fmh_store.sv
// ----------------------------------------------------------------------------
// fmh_store
// Heap storage: four lane banks, one row of siblings read per cycle,
// one lane written per cycle, registered read data held between reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fmh_store import fmh_pkg::*; #(
   parameter int ROWS = 65,
   parameter int RW   = 7
) (
   input  logic                            clock,
   input  logic                            rd_en,
   input  logic [RW-1:0]                   rd_row,
   input  wr_type                          wr,
   input  logic [RW-1:0]                   wr_row,
   output logic [LANES-1:0][KEY_W-1:0]     rd_key,
   output logic [LANES-1:0][HDL_W-1:0]     rd_hdl
);

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      logic [KEY_W+HDL_W-1:0] bank [ROWS];
      logic [KEY_W+HDL_W-1:0] q_ff;

      always_ff @(posedge clock) begin
         if (wr.en && (wr.lane == LANE_W'(g))) begin
            bank[wr_row] <= {wr.key, wr.handle};
         end
      end

      always_ff @(posedge clock) begin
         if (rd_en) begin
            q_ff <= bank[rd_row];
         end
      end

      assign rd_key[g] = q_ff[KEY_W+HDL_W-1:HDL_W];
      assign rd_hdl[g] = q_ff[HDL_W-1:0];
   end

endmodule

`default_nettype wire

// File: design/fmh_ctrl.sv
// ----------------------------------------------------------------------------
// fmh_ctrl
// Sift sequencer: reads a parent or a row of children, compares, writes
// the displaced entry back and issues one result per placement or range error.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fmh_ctrl import fmh_pkg::*; #(
   parameter int DEPTH = 256,
   parameter int RW    = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  func_type                    func,
   input  logic [SLOT_W-1:0]           index,
   input  logic [CNT_W-1:0]            count,
   input  logic [KEY_W-1:0]            time_req,
   input  logic [HDL_W-1:0]            handle,
   input  logic                        out_free,
   output logic                        busy,
   output logic                        rd_en,
   output logic [RW-1:0]               rd_row,
   input  logic [LANES-1:0][KEY_W-1:0] rd_key,
   input  logic [LANES-1:0][HDL_W-1:0] rd_hdl,
   output wr_type                      wr,
   output logic [RW-1:0]               wr_row,
   output logic                        emit,
   output result_type                  result
);

   localparam int                CB_W      = SLOT_W + 3;
   localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(DEPTH);

   state_type          state_ff, state_in;
   func_type           func_ff;
   logic               adj_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [HDL_W-1:0]   hdl_ff;
   logic [KEY_W-1:0]   p0_key_ff, p1_key_ff, min_key_ff;
   logic [HDL_W-1:0]   p0_hdl_ff, p1_hdl_ff, min_hdl_ff;
   logic [LANE_W-1:0]  p0_lane_ff, p1_lane_ff, min_lane_ff;
   logic               p1_ok_ff;

   logic [CNT_W-1:0]      cnt_eff;
   logic                  req_bad;
   logic [ROW_FULL_W-1:0] req_row_full, own_row_full, par_row_full, gp_row_full;
   logic [ROW_FULL_W-1:0] child_row_full, m_child_row_full;
   logic [SLOT_W-1:0]     par, m;
   logic [LANE_W-1:0]     own_lane, par_lane;
   logic [KEY_W-1:0]      par_key;
   logic [HDL_W-1:0]      par_hdl;
   logic [CB_W-1:0]       cbase, mbase, cnt_wide;
   logic [LANES-1:0]      lv;
   logic                  c_ok, m_c_ok, load_up, up_to_down, up_stop, dn_stop;
   logic                  pick1, pick3, pick_r;

   always_comb begin
      cnt_eff      = (count > DEPTH_CNT) ? DEPTH_CNT : count;
      req_bad      = ({1'b0, index} >= cnt_eff);
      req_row_full = row_of(index);
      own_row_full = row_of(slot_ff);
      own_lane     = lane_of(slot_ff);
      par          = parent_of(slot_ff);
      par_lane     = lane_of(par);
      par_row_full = row_of(par);
      gp_row_full  = row_of(parent_of(par));
      par_key      = rd_key[par_lane];
      par_hdl      = rd_hdl[par_lane];
      cnt_wide     = {2'b00, cnt_ff};
      cbase        = {1'b0, slot_ff, 2'b00} + CB_W'(1);
      c_ok         = (cbase < cnt_wide);
      child_row_full = ROW_FULL_W'({1'b0, slot_ff} + (SLOT_W+1)'(1));
      m            = SLOT_W'(cbase) + SLOT_W'(min_lane_ff);
      mbase        = {1'b0, m, 2'b00} + CB_W'(1);
      m_c_ok       = (mbase < cnt_wide);
      m_child_row_full = ROW_FULL_W'({1'b0, m} + (SLOT_W+1)'(1));
      for (int j = 0; j < LANES; j++) begin
         lv[j] = ((cbase + CB_W'(j)) < cnt_wide);
      end
      load_up    = (func_ff == FUNC_UP) || ((func_ff == FUNC_ADJUST) && (slot_ff != '0));
      up_to_down = adj_ff && (par_key < key_ff);
      up_stop    = (par_key <= key_ff);
      dn_stop    = (key_ff <= min_key_ff);
      pick1      = lv[1] && (rd_key[1] < rd_key[0]);
      pick3      = lv[3] && (rd_key[3] < rd_key[2]);
      pick_r     = p1_ok_ff && (p1_key_ff < p0_key_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_bad) begin
                  state_in = ST_ERROR;
               end else if (func == FUNC_WRITE) begin
                  state_in = ST_PLACE;
               end else begin
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            if (load_up) begin
               state_in = (slot_ff == '0) ? ST_PLACE : ST_UP_CMP;
            end else begin
               state_in = c_ok ? ST_DN_PAIR : ST_PLACE;
            end
         end
         ST_UP_CMP: begin
            priority if (up_to_down) begin
               state_in = c_ok ? ST_DN_PAIR : ST_PLACE;
            end else if (up_stop) begin
               state_in = ST_PLACE;
            end else if (out_free) begin
               state_in = (par == '0) ? ST_PLACE : ST_UP_CMP;
            end
         end
         ST_DN_PAIR: state_in = ST_DN_MIN;
         ST_DN_MIN:  state_in = ST_DN_MOVE;
         ST_DN_MOVE: begin
            priority if (dn_stop) begin
               state_in = ST_PLACE;
            end else if (out_free) begin
               state_in = m_c_ok ? ST_DN_PAIR : ST_PLACE;
            end
         end
         ST_PLACE, ST_ERROR: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy       = (state_ff != ST_IDLE);
      rd_en      = 1'b0;
      rd_row     = own_row_full[RW-1:0];
      wr.en      = 1'b0;
      wr.lane    = own_lane;
      wr.key     = key_ff;
      wr.handle  = hdl_ff;
      wr_row     = own_row_full[RW-1:0];
      emit       = 1'b0;
      result.moved_handle = hdl_ff;
      result.position     = {1'b0, slot_ff} + CNT_W'(1);
      result.status       = STATUS_OK;
      result.last         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            rd_en  = start && !req_bad && (func != FUNC_WRITE);
            rd_row = req_row_full[RW-1:0];
         end
         ST_LOAD: begin
            if (load_up) begin
               rd_en  = (slot_ff != '0);
               rd_row = par_row_full[RW-1:0];
            end else begin
               rd_en  = c_ok;
               rd_row = child_row_full[RW-1:0];
            end
         end
         ST_UP_CMP: begin
            priority if (up_to_down) begin
               rd_en  = c_ok;
               rd_row = child_row_full[RW-1:0];
            end else if (!up_stop && out_free) begin
               wr.en     = 1'b1;
               wr.key    = par_key;
               wr.handle = par_hdl;
               emit      = 1'b1;
               result.moved_handle = par_hdl;
               rd_en  = (par != '0);
               rd_row = gp_row_full[RW-1:0];
            end else begin
               rd_en = 1'b0;
            end
         end
         ST_DN_PAIR, ST_DN_MIN: begin
            rd_en = 1'b0;
         end
         ST_DN_MOVE: begin
            if (!dn_stop && out_free) begin
               wr.en     = 1'b1;
               wr.key    = min_key_ff;
               wr.handle = min_hdl_ff;
               emit      = 1'b1;
               result.moved_handle = min_hdl_ff;
               rd_en  = m_c_ok;
               rd_row = m_child_row_full[RW-1:0];
            end
         end
         ST_PLACE: begin
            wr.en       = out_free;
            emit        = out_free;
            result.last = 1'b1;
         end
         ST_ERROR: begin
            emit                = out_free;
            result.moved_handle = '0;
            result.position     = '0;
            result.status       = STATUS_RANGE;
            result.last         = 1'b1;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_ff <= func;
               slot_ff <= index;
               cnt_ff  <= cnt_eff;
               key_ff  <= time_req;
               hdl_ff  <= handle;
            end
         end
         ST_LOAD: begin
            key_ff <= rd_key[own_lane];
            hdl_ff <= rd_hdl[own_lane];
            adj_ff <= (func_ff == FUNC_ADJUST);
         end
         ST_UP_CMP: begin
            if (!up_to_down && !up_stop && out_free) begin
               slot_ff <= par;
               adj_ff  <= 1'b0;
            end
         end
         ST_DN_PAIR: begin
            p0_key_ff  <= pick1 ? rd_key[1] : rd_key[0];
            p0_hdl_ff  <= pick1 ? rd_hdl[1] : rd_hdl[0];
            p0_lane_ff <= pick1 ? LANE_W'(1) : LANE_W'(0);
            p1_key_ff  <= pick3 ? rd_key[3] : rd_key[2];
            p1_hdl_ff  <= pick3 ? rd_hdl[3] : rd_hdl[2];
            p1_lane_ff <= pick3 ? LANE_W'(3) : LANE_W'(2);
            p1_ok_ff   <= lv[2];
         end
         ST_DN_MIN: begin
            min_key_ff  <= pick_r ? p1_key_ff : p0_key_ff;
            min_hdl_ff  <= pick_r ? p1_hdl_ff : p0_hdl_ff;
            min_lane_ff <= pick_r ? p1_lane_ff : p0_lane_ff;
         end
         ST_DN_MOVE: begin
            if (!dn_stop && out_free) begin
               slot_ff <= m;
            end
         end
         ST_PLACE, ST_ERROR: begin
            adj_ff <= 1'b0;
         end
         default: begin
            adj_ff <= 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: design/four_ary_min_heap_sift.sv
// ----------------------------------------------------------------------------
// four_ary_min_heap_sift
// Timer store kept as a four-ary min-heap: sift up, sift down, adjust or
// plain write of one slot, one result per entry placed.
//
//   channel   dir  handshake           fields
//   req_      in   req_valid/req_stall func, index, count, time_req, handle
//   rsp_      out  rsp_valid/rsp_stall moved_handle, position, status, last
//
// Write or out-of-range item: straight to placement or error. Sift up: load,
// then one parent compare per level moved, one more when it stops below the
// root. Sift down: load, then per child row examined a row read, two-level
// child minimum, compare and write-back; adjust below the root adds one
// parent compare.
// One item at a time; req_stall is high from acceptance until the last
// result is loaded into the output register.
// Reset clears control only; slots read before being written give no
// defined data. A stalled rsp_ holds the sequencer at its next placement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "four_ary_min_heap_sift_assert.svh"

module four_ary_min_heap_sift import fmh_pkg::*; #(
   parameter int CAPACITY = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [SLOT_W-1:0]  req_index,
   input  logic [CNT_W-1:0]   req_count,
   input  logic [KEY_W-1:0]   req_time_req,
   input  logic [HDL_W-1:0]   req_handle,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [HDL_W-1:0]   rsp_moved_handle,
   output logic [CNT_W-1:0]   rsp_position,
   output logic               rsp_status,
   output logic               rsp_last
);

   localparam int DEPTH = (CAPACITY < (1 << SLOT_W)) ? CAPACITY : (1 << SLOT_W);
   localparam int ROWS  = ((DEPTH + LANES - 2) / LANES) + 1;
   localparam int RW    = $clog2(ROWS);

   logic                        start, busy, out_free, emit, rd_en;
   logic [RW-1:0]               rd_row, wr_row;
   logic [LANES-1:0][KEY_W-1:0] rd_key;
   logic [LANES-1:0][HDL_W-1:0] rd_hdl;
   wr_type                      wr;
   result_type                  result;
   logic                        rsp_valid_ff, rsp_valid_in;
   result_type                  rsp_ff;

   assign start    = req_valid && !busy;
   assign req_stall = busy;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   fmh_ctrl #(
      .DEPTH (DEPTH),
      .RW    (RW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .func     (func_type'(req_func)),
      .index    (req_index),
      .count    (req_count),
      .time_req (req_time_req),
      .handle   (req_handle),
      .out_free (out_free),
      .busy     (busy),
      .rd_en    (rd_en),
      .rd_row   (rd_row),
      .rd_key   (rd_key),
      .rd_hdl   (rd_hdl),
      .wr       (wr),
      .wr_row   (wr_row),
      .emit     (emit),
      .result   (result)
   );

   fmh_store #(
      .ROWS (ROWS),
      .RW   (RW)
   ) u_store (
      .clock  (clock),
      .rd_en  (rd_en),
      .rd_row (rd_row),
      .wr     (wr),
      .wr_row (wr_row),
      .rd_key (rd_key),
      .rd_hdl (rd_hdl)
   );

   // hold a result until its transfer completes
   assign rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_moved_handle = rsp_ff.moved_handle;
   assign rsp_position     = rsp_ff.position;
   assign rsp_status       = rsp_ff.status;
   assign rsp_last         = rsp_ff.last;

   `FMH_ASSERT_NOW(a_emit_free, clock, reset, emit, out_free)
   `FMH_ASSERT_NEXT(a_busy_after_start, clock, reset, start, busy)
   `FMH_ASSERT_NEXT(a_idle_after_last, clock, reset, emit && result.last, !busy)
   `FMH_ASSERT_NOW(a_range_shape, clock, reset, rsp_valid && rsp_status, rsp_last && (rsp_position == '0))

endmodule

`default_nettype wire
